// File: design/bota_pkg.sv
// Shared types and constants for the box overlap track association block.
`timescale 1ns / 1ps
package bota_pkg;
	localparam int MaxTracks     = 8;
	localparam int MaxDetections = 8;
	localparam int ResultCap     = 16;

	localparam logic [1:0] ModeTrack  = 2'd0;
	localparam logic [1:0] ModeDet    = 2'd1;
	localparam logic [1:0] ModeRun    = 2'd2;

	localparam logic [1:0] CatNone    = 2'd0;
	localparam logic [1:0] CatMatch   = 2'd1;
	localparam logic [1:0] CatSeveral = 2'd2;
	localparam logic [1:0] CatShared  = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        track_id;
		logic signed [15:0] box_x;
		logic signed [15:0] box_y;
		logic [14:0]        box_w;
		logic [14:0]        box_h;
	} in_item_t;

	typedef struct packed {
		logic        is_empty;
		logic        side;
		logic [2:0]  slot;
		logic [15:0] owner_id;
		logic [1:0]  category;
		logic [7:0]  partner_mask;
		logic        last;
	} out_item_t;

	// Box as stored: x, y, w, h.
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} box_t;

	// Controller to datapath.
	typedef struct packed {
		logic load_trk;
		logic load_det;
		logic pair_en;    // test pair (row, col) into matrix
		logic emit;       // form result at (side, idx) into output register
		logic side;
		logic clear;
	} dp_cmd_t;
endpackage

// File: design/bota_if.sv
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface bota_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/bota_ctrl.sv
// Controller: sequences loads, the pair sweep and result emission.
`timescale 1ns / 1ps
module bota_ctrl #(
	parameter int MAX_TRACKS     = bota_pkg::MaxTracks,
	parameter int MAX_DETECTIONS = bota_pkg::MaxDetections,
	localparam int TW = $clog2(MAX_TRACKS + 1),
	localparam int DW = $clog2(MAX_DETECTIONS + 1),
	localparam int IW = (TW > DW) ? TW : DW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_mode,
	output logic               in_ready,
	input  logic               out_full,
	input  logic               out_take,
	output bota_pkg::dp_cmd_t  cmd,
	output logic [IW-1:0]      row,
	output logic [IW-1:0]      col,
	output logic               emit_empty,
	output logic               emit_last
);
	typedef enum logic [1:0] {IDLE, SWEEP, EMIT} state_t;
	state_t state_q;
	logic [TW-1:0] tcnt_q;
	logic [DW-1:0] dcnt_q;
	logic [IW-1:0] r_q, c_q;
	logic [4:0] k_q;
	logic side_q;
	logic acc, can_emit, fin_side, lastr;
	logic [IW-1:0] idx_n;

	// hold input while a result waits, so an empty run always has room to emit
	assign in_ready = (state_q == IDLE) && can_emit;
	assign acc = in_valid && in_ready;
	assign can_emit = !out_full || out_take;
	assign row = r_q;
	assign col = c_q;

	always_comb begin
		idx_n = r_q + IW'(1);
		fin_side = side_q ? (idx_n >= IW'(tcnt_q)) : (idx_n >= IW'(dcnt_q));
		// last when cap reached, on the track side when tracks run out, or when detections run out and no tracks follow
		lastr = (k_q == 5'(bota_pkg::ResultCap - 1)) ||
			(side_q ? fin_side : (fin_side && tcnt_q == '0));
		emit_last = lastr;
		emit_empty = 1'b0;
		cmd = '0;
		cmd.load_trk = acc && in_mode == bota_pkg::ModeTrack && tcnt_q < TW'(MAX_TRACKS);
		cmd.load_det = acc && in_mode == bota_pkg::ModeDet && dcnt_q < DW'(MAX_DETECTIONS);
		cmd.pair_en = (state_q == SWEEP);
		cmd.side = side_q;
		if (state_q == EMIT && can_emit) begin
			cmd.emit = 1'b1;
			cmd.clear = lastr;
		end
		if (acc && in_mode == bota_pkg::ModeRun && tcnt_q == '0 && dcnt_q == '0 &&
				can_emit) begin
			cmd.emit = 1'b1;
			emit_empty = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			tcnt_q <= '0;
			dcnt_q <= '0;
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
			side_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (cmd.load_trk) tcnt_q <= tcnt_q + TW'(1);
					if (cmd.load_det) dcnt_q <= dcnt_q + DW'(1);
					if (acc && in_mode == bota_pkg::ModeRun &&
							!(tcnt_q == '0 && dcnt_q == '0)) begin
						r_q <= '0;
						c_q <= '0;
						if (tcnt_q == '0 || dcnt_q == '0) begin
							state_q <= EMIT;
							side_q <= (dcnt_q == '0);
							k_q <= '0;
						end else begin
							state_q <= SWEEP;
						end
					end
				end
				SWEEP: begin
					if (c_q + IW'(1) >= IW'(tcnt_q)) begin
						c_q <= '0;
						if (r_q + IW'(1) >= IW'(dcnt_q)) begin
							r_q <= '0;
							state_q <= EMIT;
							side_q <= 1'b0;
							k_q <= '0;
						end else begin
							r_q <= r_q + IW'(1);
						end
					end else begin
						c_q <= c_q + IW'(1);
					end
				end
				EMIT: begin
					if (can_emit) begin
						k_q <= k_q + 5'd1;
						if (lastr) begin
							state_q <= IDLE;
							tcnt_q <= '0;
							dcnt_q <= '0;
						end else if (fin_side) begin
							side_q <= 1'b1;
							r_q <= '0;
						end else begin
							r_q <= idx_n;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// File: design/bota_dp.sv
// Datapath: box stores, overlap matrix and result register.
`timescale 1ns / 1ps
module bota_dp #(
	parameter int MAX_TRACKS     = bota_pkg::MaxTracks,
	parameter int MAX_DETECTIONS = bota_pkg::MaxDetections,
	localparam int TW = $clog2(MAX_TRACKS + 1),
	localparam int DW = $clog2(MAX_DETECTIONS + 1),
	localparam int IW = (TW > DW) ? TW : DW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bota_pkg::in_item_t  in_data,
	input  bota_pkg::dp_cmd_t   cmd,
	input  logic [TW-1:0]       tcnt,
	input  logic [DW-1:0]       dcnt,
	input  logic [IW-1:0]       row,
	input  logic [IW-1:0]       col,
	input  logic                emit_empty,
	input  logic                emit_last,
	input  logic                out_take,
	output logic                out_full,
	output bota_pkg::out_item_t out_data
);
	localparam int TI = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int DI = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;

	bota_pkg::box_t trk_q [MAX_TRACKS];
	logic [15:0]    tid_q [MAX_TRACKS];
	bota_pkg::box_t det_q [MAX_DETECTIONS];
	logic [MAX_TRACKS-1:0] mat_q [MAX_DETECTIONS];
	logic full_q;
	bota_pkg::out_item_t out_q, res;
	bota_pkg::box_t nb, ta, db;
	logic touch;
	logic signed [16:0] lx, ly, rx, ry, ar, br, ab, bb;
	logic [MAX_TRACKS-1:0] rmask, cand_row;
	logic [MAX_DETECTIONS-1:0] cmask, cand_col;
	logic [TI-1:0] ti, ti_p;
	logic [DI-1:0] di, di_p;
	logic one, one_p, any;
	logic [1:0] cat;
	logic [7:0] pm;

	assign nb = '{x: in_data.box_x, y: in_data.box_y, w: in_data.box_w, h: in_data.box_h};
	assign ti = TI'(tcnt);
	assign di = DI'(dcnt);
	assign ta = trk_q[TI'(col)];
	assign db = det_q[DI'(row)];

	always_comb begin
		lx = (ta.x > db.x) ? 17'(ta.x) : 17'(db.x);
		ly = (ta.y > db.y) ? 17'(ta.y) : 17'(db.y);
		ar = 17'(ta.x) + $signed({2'b0, ta.w});
		br = 17'(db.x) + $signed({2'b0, db.w});
		ab = 17'(ta.y) + $signed({2'b0, ta.h});
		bb = 17'(db.y) + $signed({2'b0, db.h});
		rx = (ar < br) ? ar : br;
		ry = (ab < bb) ? ab : bb;
		touch = (rx > lx) && (ry > ly);
	end

	// Row and column of the box being emitted, plus its partner's line.
	always_comb begin
		rmask = mat_q[DI'(row)];
		for (int r = 0; r < MAX_DETECTIONS; r++) cmask[r] = mat_q[r][TI'(row)];
		ti_p = '0;
		for (int c = MAX_TRACKS - 1; c >= 0; c--) if (rmask[c]) ti_p = TI'(c);
		di_p = '0;
		for (int r = MAX_DETECTIONS - 1; r >= 0; r--) if (cmask[r]) di_p = DI'(r);
		for (int r = 0; r < MAX_DETECTIONS; r++) cand_col[r] = mat_q[r][ti_p];
		cand_row = mat_q[di_p];
		if (!cmd.side) begin
			any = |rmask;
			one = $onehot(rmask);
			one_p = $onehot(cand_col);
			pm = 8'(rmask);
		end else begin
			any = |cmask;
			one = $onehot(cmask);
			one_p = $onehot(cand_row);
			pm = 8'(cmask);
		end
		if (!any) cat = bota_pkg::CatNone;
		else if (!one) cat = bota_pkg::CatSeveral;
		else cat = one_p ? bota_pkg::CatMatch : bota_pkg::CatShared;
	end

	always_comb begin
		res = '0;
		if (emit_empty) begin
			res.is_empty = 1'b1;
			res.last = 1'b1;
		end else begin
			res.side = cmd.side;
			res.slot = 3'(row);
			res.owner_id = cmd.side ? tid_q[TI'(row)] : 16'd0;
			res.category = cat;
			res.partner_mask = pm;
			res.last = emit_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_trk) begin
			trk_q[ti] <= nb;
			tid_q[ti] <= in_data.track_id;
		end
		if (cmd.load_det) det_q[di] <= nb;
		if (cmd.emit) out_q <= res;
	end

	// Matrix rows clear after each run so stale bits never read as overlap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_DETECTIONS; r++) mat_q[r] <= '0;
			full_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				for (int r = 0; r < MAX_DETECTIONS; r++) mat_q[r] <= '0;
			end else if (cmd.pair_en) begin
				mat_q[DI'(row)][TI'(col)] <= touch;
			end
			if (cmd.emit) full_q <= 1'b1;
			else if (out_take) full_q <= 1'b0;
		end
	end

	assign out_full = full_q;
	assign out_data = out_q;
endmodule

// File: design/box_overlap_track_association.sv
// Box overlap track association: loads boxes, sweeps pairs, emits per-box results.
// Load items: accepted while idle; input is ready again after each load.
// Compute: every track-detection pair (tracks x detections) is tested, then one
// result per box (detections, then tracks) leaves while the output register drains.
// A result register sits on the output; a new result enters as the old one transfers.
// Input stalls during a run and while a result waits there. Reset clears counts, matrix and output valid.
`timescale 1ns / 1ps
module box_overlap_track_association #(
	parameter int MAX_TRACKS     = bota_pkg::MaxTracks,
	parameter int MAX_DETECTIONS = bota_pkg::MaxDetections
) (
	input logic clk,
	input logic arst_n,
	bota_if.sink   in_ch,
	bota_if.source out_ch
);
	localparam int TW = $clog2(MAX_TRACKS + 1);
	localparam int DW = $clog2(MAX_DETECTIONS + 1);
	localparam int IW = (TW > DW) ? TW : DW;

	bota_pkg::dp_cmd_t cmd;
	logic [IW-1:0] row, col;
	logic emit_empty, emit_last, out_full, take;
	logic [TW-1:0] tcnt_q;
	logic [DW-1:0] dcnt_q;

	assign take = out_ch.valid && out_ch.ready;
	assign out_ch.valid = out_full;

	// Mirror of the controller's counts for store addressing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcnt_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.clear) begin
			tcnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.load_trk) tcnt_q <= tcnt_q + TW'(1);
			if (cmd.load_det) dcnt_q <= dcnt_q + DW'(1);
		end
	end

	bota_ctrl #(.MAX_TRACKS(MAX_TRACKS), .MAX_DETECTIONS(MAX_DETECTIONS)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_mode(in_ch.data.mode), .in_ready(in_ch.ready),
		.out_full, .out_take(take), .cmd, .row, .col, .emit_empty, .emit_last
	);

	bota_dp #(.MAX_TRACKS(MAX_TRACKS), .MAX_DETECTIONS(MAX_DETECTIONS)) u_dp (
		.clk, .arst_n, .in_data(in_ch.data), .cmd, .tcnt(tcnt_q), .dcnt(dcnt_q),
		.row, .col, .emit_empty, .emit_last, .out_take(take), .out_full,
		.out_data(out_ch.data)
	);
endmodule

// File: design/bota_chk.sv
// Port-level checker for the association block, bound to the top level.
`timescale 1ns / 1ps
module bota_chk (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input bota_pkg::out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while a result waits");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_empty |-> out_data.last && out_data.category == '0
		&& out_data.partner_mask == '0)
		else $error("empty result malformed");
	a_owner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.side |-> out_data.owner_id == '0)
		else $error("detection result has owner");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.partner_mask == '0 && !out_data.is_empty
		|-> out_data.category == bota_pkg::CatNone)
		else $error("category without partners");
endmodule

bind box_overlap_track_association bota_chk u_chk (
	.clk, .arst_n,
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
